// File: sv/gtg_pkg.sv
// ============================================================================
// gtg_pkg
// Shared types, constants and the microcode program for the go-to-goal
// proportional controller.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package gtg_pkg;

  // Field widths.
  localparam int POS_W   = 16;  // Q6.10 positions
  localparam int HEAD_W  = 15;  // Q3.12 heading
  localparam int TOL_W   = 17;  // Q7.10 tolerance and distance
  localparam int GAIN_W  = 12;  // Q4.8 gains
  localparam int LIN_W   = 18;  // Q8.10 linear speed
  localparam int ANG_W   = 19;  // Q7.12 angular rate
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Iteration counts. The square root takes one result bit per step.
  localparam int CORDIC_ITERATIONS = 16;
  localparam int SQRT_STEPS        = 17;
  localparam int LOOP_LEN = (CORDIC_ITERATIONS > SQRT_STEPS) ? CORDIC_ITERATIONS : SQRT_STEPS;
  localparam int ITER_W   = $clog2(LOOP_LEN);
  localparam int PC_W     = 4;

  // Angle constants, Q.16 accumulator and Q3.12 bearing.
  localparam logic signed [19:0] ANG_HALF_PI   = 20'sd102944;
  localparam logic signed [19:0] BEARING_LIMIT = 20'sd12868;

  // Output limits.
  localparam logic signed [35:0] LIN_MAX = 36'sd262143;
  localparam logic signed [35:0] ANG_MAX = 36'sd262143;
  localparam logic signed [35:0] ANG_MIN = -36'sd262144;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GOAL_X   = 3'd0,
    REG_GOAL_Y   = 3'd1,
    REG_TOL      = 3'd2,
    REG_LIN_GAIN = 3'd3,
    REG_ANG_GAIN = 3'd4
  } cfg_reg_t;

  // Datapath micro-operations.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_SQX,    // square dx, set up the CORDIC vector
    OP_SQY,    // square dy, hold dx squared
    OP_SUM,    // form the radicand, clear the root
    OP_ITER,   // one square-root step and one CORDIC step
    OP_ROUND,  // round the root, finish the bearing and heading error
    OP_MLIN,   // linear gain times distance
    OP_MANG,   // saturate speed, angular gain times heading error
    OP_EMIT    // hand the result to the output register
  } uop_t;

  // Sequencer branch conditions.
  typedef enum logic [2:0] {
    COND_NEXT,   // fall through
    COND_START,  // wait for an input beat
    COND_LOOP,   // repeat until the iteration counter is at its last value
    COND_EMIT,   // wait for a free output register, then jump
    COND_JUMP    // unconditional jump
  } cond_t;

  typedef struct packed {
    uop_t            op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // Control sent from the sequencer to the datapath.
  typedef struct packed {
    logic              load;
    uop_t              op;
    logic [ITER_W-1:0] iter;
  } gtg_ctl_t;

  localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] PC_LOOP = 4'd4;

  // Microcode program.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{op: OP_NOP,   cond: COND_START, target: PC_IDLE};
      4'd1:    w = '{op: OP_SQX,   cond: COND_NEXT,  target: PC_IDLE};
      4'd2:    w = '{op: OP_SQY,   cond: COND_NEXT,  target: PC_IDLE};
      4'd3:    w = '{op: OP_SUM,   cond: COND_NEXT,  target: PC_IDLE};
      4'd4:    w = '{op: OP_ITER,  cond: COND_LOOP,  target: PC_LOOP};
      4'd5:    w = '{op: OP_ROUND, cond: COND_NEXT,  target: PC_IDLE};
      4'd6:    w = '{op: OP_MLIN,  cond: COND_NEXT,  target: PC_IDLE};
      4'd7:    w = '{op: OP_MANG,  cond: COND_NEXT,  target: PC_IDLE};
      4'd8:    w = '{op: OP_EMIT,  cond: COND_EMIT,  target: PC_IDLE};
      default: w = '{op: OP_NOP,   cond: COND_JUMP,  target: PC_IDLE};
    endcase
    return w;
  endfunction

  // atan(2^-i) in Q.16 radians.
  function automatic logic [16:0] atan_q16(input logic [ITER_W-1:0] i);
    logic [16:0] v;
    case (i)
      0:       v = 17'd51472;
      1:       v = 17'd30386;
      2:       v = 17'd16055;
      3:       v = 17'd8150;
      4:       v = 17'd4091;
      5:       v = 17'd2047;
      6:       v = 17'd1024;
      7:       v = 17'd512;
      8:       v = 17'd256;
      9:       v = 17'd128;
      10:      v = 17'd64;
      11:      v = 17'd32;
      12:      v = 17'd16;
      13:      v = 17'd8;
      14:      v = 17'd4;
      15:      v = 17'd2;
      16:      v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: sv/gtg_dp.sv
// ============================================================================
// gtg_dp
// Datapath of the controller: offset capture, one shared multiplier, a
// one-bit-per-step square root and a vectoring CORDIC stepped together.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module gtg_dp (
  input  wire                                 clk,
  input  wire gtg_pkg::gtg_ctl_t              ctl,
  input  wire signed [gtg_pkg::POS_W-1:0]     goal_x,
  input  wire signed [gtg_pkg::POS_W-1:0]     goal_y,
  input  wire        [gtg_pkg::TOL_W-1:0]     tol,
  input  wire        [gtg_pkg::GAIN_W-1:0]    lin_gain,
  input  wire        [gtg_pkg::GAIN_W-1:0]    ang_gain,
  input  wire signed [gtg_pkg::POS_W-1:0]     pose_x,
  input  wire signed [gtg_pkg::POS_W-1:0]     pose_y,
  input  wire signed [gtg_pkg::HEAD_W-1:0]    pose_heading,
  output logic                                near,
  output logic       [gtg_pkg::LIN_W-1:0]     lin_speed,
  output logic signed [gtg_pkg::ANG_W-1:0]    ang_rate
);

  // Captured operands.
  logic signed [16:0] dx_r, dy_r;
  logic signed [gtg_pkg::HEAD_W-1:0] hd_r;

  // Multiplier and square-root state.
  logic signed [35:0] prod_r;
  logic        [33:0] sum_r;
  logic        [33:0] rad_r;
  logic        [19:0] rem_r;
  logic        [16:0] root_r;

  // CORDIC state.
  logic signed [27:0] x_r, y_r;
  logic signed [19:0] z_r;

  // Results.
  logic        [gtg_pkg::TOL_W-1:0] dist_r;
  logic                             near_r;
  logic signed [16:0]               err_r;
  logic        [gtg_pkg::LIN_W-1:0] lin_r;

  // Combinational helpers.
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] mul_p;
  logic signed [27:0] xs0, ys0, x_sh, y_sh;
  logic        [19:0] rem_sh, trial;
  logic signed [19:0] z_rnd;
  logic signed [15:0] bear;
  logic signed [35:0] p_rnd;
  logic [gtg_pkg::TOL_W-1:0] dist_nxt;
  logic                      sqrt_en, cordic_en;

  // Operand select for the shared multiplier.
  always_comb begin
    case (ctl.op)
      gtg_pkg::OP_SQX: begin
        mul_a = {dx_r[16], dx_r};
        mul_b = {dx_r[16], dx_r};
      end
      gtg_pkg::OP_SQY: begin
        mul_a = {dy_r[16], dy_r};
        mul_b = {dy_r[16], dy_r};
      end
      gtg_pkg::OP_MLIN: begin
        mul_a = $signed({6'd0, lin_gain});
        mul_b = $signed({1'b0, dist_r});
      end
      gtg_pkg::OP_MANG: begin
        mul_a = $signed({6'd0, ang_gain});
        mul_b = {err_r[16], err_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Offset scaled by 256 and CORDIC shifted terms.
  assign xs0  = {{3{dx_r[16]}}, dx_r, 8'h00};
  assign ys0  = {{3{dy_r[16]}}, dy_r, 8'h00};
  assign x_sh = x_r >>> ctl.iter;
  assign y_sh = y_r >>> ctl.iter;

  // Square-root step: bring down two radicand bits and try the next root bit.
  assign rem_sh = {rem_r[17:0], rad_r[33:32]};
  assign trial  = {1'b0, root_r, 2'b01};

  assign sqrt_en   = int'(ctl.iter) < gtg_pkg::SQRT_STEPS;
  assign cordic_en = int'(ctl.iter) < gtg_pkg::CORDIC_ITERATIONS;

  // Rounded distance and the clamped bearing in Q3.12.
  always_comb begin
    dist_nxt = root_r + {16'd0, (rem_r > {3'd0, root_r})};
    z_rnd    = (z_r + 20'sd8) >>> 4;
    if (z_rnd > gtg_pkg::BEARING_LIMIT) begin
      bear = gtg_pkg::BEARING_LIMIT[15:0];
    end else if (z_rnd < -gtg_pkg::BEARING_LIMIT) begin
      bear = 16'(-gtg_pkg::BEARING_LIMIT);
    end else begin
      bear = z_rnd[15:0];
    end
  end

  // Round the product by half an LSB of Q.8 and drop eight bits.
  assign p_rnd = (prod_r + 36'sd128) >>> 8;

  // Datapath registers, advanced by the micro-operation.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dx_r <= $signed({goal_x[15], goal_x}) - $signed({pose_x[15], pose_x});
      dy_r <= $signed({goal_y[15], goal_y}) - $signed({pose_y[15], pose_y});
      hd_r <= pose_heading;
    end
    case (ctl.op)
      gtg_pkg::OP_SQX: begin
        prod_r <= mul_p;
        // Turn a vector with negative x by a quarter turn.
        if (dx_r < 0) begin
          if (dy_r >= 0) begin
            x_r <= ys0;
            y_r <= -xs0;
            z_r <= gtg_pkg::ANG_HALF_PI;
          end else begin
            x_r <= -ys0;
            y_r <= xs0;
            z_r <= -gtg_pkg::ANG_HALF_PI;
          end
        end else begin
          x_r <= xs0;
          y_r <= ys0;
          z_r <= '0;
        end
      end
      gtg_pkg::OP_SQY: begin
        sum_r  <= prod_r[33:0];
        prod_r <= mul_p;
      end
      gtg_pkg::OP_SUM: begin
        rad_r  <= sum_r + prod_r[33:0];
        rem_r  <= '0;
        root_r <= '0;
      end
      gtg_pkg::OP_ITER: begin
        if (sqrt_en) begin
          rad_r <= {rad_r[31:0], 2'b00};
          if (rem_sh >= trial) begin
            rem_r  <= rem_sh - trial;
            root_r <= {root_r[15:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            root_r <= {root_r[15:0], 1'b0};
          end
        end
        if (cordic_en) begin
          if (y_r >= 0) begin
            x_r <= x_r + y_sh;
            y_r <= y_r - x_sh;
            z_r <= z_r + $signed({3'd0, gtg_pkg::atan_q16(ctl.iter)});
          end else begin
            x_r <= x_r - y_sh;
            y_r <= y_r + x_sh;
            z_r <= z_r - $signed({3'd0, gtg_pkg::atan_q16(ctl.iter)});
          end
        end
      end
      gtg_pkg::OP_ROUND: begin
        dist_r <= dist_nxt;
        near_r <= dist_nxt < tol;
        err_r  <= $signed({bear[15], bear}) - $signed({{2{hd_r[14]}}, hd_r});
      end
      gtg_pkg::OP_MLIN: begin
        prod_r <= mul_p;
      end
      gtg_pkg::OP_MANG: begin
        // Product is never negative here.
        if (p_rnd > gtg_pkg::LIN_MAX) begin
          lin_r <= gtg_pkg::LIN_MAX[17:0];
        end else begin
          lin_r <= p_rnd[17:0];
        end
        prod_r <= mul_p;
      end
      default: begin
      end
    endcase
  end

  // Saturated angular rate straight from the last product.
  always_comb begin
    if (p_rnd > gtg_pkg::ANG_MAX) begin
      ang_rate = gtg_pkg::ANG_MAX[18:0];
    end else if (p_rnd < gtg_pkg::ANG_MIN) begin
      ang_rate = gtg_pkg::ANG_MIN[18:0];
    end else begin
      ang_rate = p_rnd[18:0];
    end
  end

  assign near      = near_r;
  assign lin_speed = lin_r;

endmodule

`default_nettype wire

// File: sv/go_to_goal_p_controller.sv
// ============================================================================
// go_to_goal_p_controller
// Proportional go-to-goal controller: distance and bearing to a configured
// goal from one pose sample, speed and turn-rate commands out.
// ============================================================================
//
//   Channel  Ports                                         Direction
//   -------  --------------------------------------------  ---------
//   in       in_valid, in_stall, in_pose_x/y/heading        sink
//   out      out_valid, out_stall, out_linear_speed, ...    source
//   cfg      cfg_wr_en, cfg_index, cfg_wdata                sink
//
// Each pose beat runs through the microcode program from acceptance to the
// next acceptance: the accept step, three setup steps, LOOP_LEN (17) steps
// of the shared square root and CORDIC loop, and four steps for rounding,
// the two multiplies and the hand-off.
// Synchronous active-low reset returns the sequencer to idle, empties the
// output register and restores the register defaults.
// A stalled output holds the sequencer on its final step; a new beat is taken
// as soon as the sequencer is idle, even while a result waits on out.
//
`timescale 1ns / 1ps
`default_nettype none

module go_to_goal_p_controller (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // Pose input
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire signed [gtg_pkg::POS_W-1:0]      in_pose_x,
  input  wire signed [gtg_pkg::POS_W-1:0]      in_pose_y,
  input  wire signed [gtg_pkg::HEAD_W-1:0]     in_pose_heading,
  // Command output
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic       [gtg_pkg::LIN_W-1:0]      out_linear_speed,
  output logic signed [gtg_pkg::ANG_W-1:0]     out_angular_rate,
  output logic                                 out_goal_reached,
  // Configuration
  input  wire                                  cfg_wr_en,
  input  wire        [gtg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire        [gtg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers and the reached latch.
  logic signed [gtg_pkg::POS_W-1:0]  goal_x_r, goal_y_r;
  logic        [gtg_pkg::TOL_W-1:0]  tol_r;
  logic        [gtg_pkg::GAIN_W-1:0] lin_gain_r, ang_gain_r;
  logic                              reached_r;

  // Sequencer.
  logic [gtg_pkg::PC_W-1:0]   pc_r, pc_nxt;
  logic [gtg_pkg::ITER_W-1:0] iter_r, iter_nxt;
  gtg_pkg::uword_t            uword;
  gtg_pkg::gtg_ctl_t          ctl;

  // Output register.
  logic                              out_valid_r;
  logic       [gtg_pkg::LIN_W-1:0]   out_lin_r;
  logic signed [gtg_pkg::ANG_W-1:0]  out_ang_r;
  logic                              out_reached_r;

  logic                              in_fire, out_free, emit_fire, hit;
  logic                              dp_near;
  logic       [gtg_pkg::LIN_W-1:0]   dp_lin;
  logic signed [gtg_pkg::ANG_W-1:0]  dp_ang;

  assign uword     = gtg_pkg::ucode(pc_r);
  assign in_stall  = (pc_r != gtg_pkg::PC_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_fire = (uword.op == gtg_pkg::OP_EMIT) && out_free;
  assign hit       = reached_r || dp_near;

  // Next step and iteration count from the control word.
  always_comb begin
    pc_nxt   = pc_r;
    iter_nxt = '0;
    case (uword.cond)
      gtg_pkg::COND_NEXT: begin
        pc_nxt = pc_r + 1'b1;
      end
      gtg_pkg::COND_START: begin
        if (in_fire) begin
          pc_nxt = pc_r + 1'b1;
        end
      end
      gtg_pkg::COND_LOOP: begin
        if (iter_r == gtg_pkg::ITER_W'(gtg_pkg::LOOP_LEN - 1)) begin
          pc_nxt = pc_r + 1'b1;
        end else begin
          pc_nxt   = uword.target;
          iter_nxt = iter_r + 1'b1;
        end
      end
      gtg_pkg::COND_EMIT: begin
        if (out_free) begin
          pc_nxt = uword.target;
        end
      end
      gtg_pkg::COND_JUMP: begin
        pc_nxt = uword.target;
      end
      default: begin
        pc_nxt = gtg_pkg::PC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= gtg_pkg::PC_IDLE;
      iter_r <= '0;
    end else begin
      pc_r   <= pc_nxt;
      iter_r <= iter_nxt;
    end
  end

  assign ctl = '{load: in_fire, op: uword.op, iter: iter_r};

  gtg_dp u_dp (
    .clk          (clk),
    .ctl          (ctl),
    .goal_x       (goal_x_r),
    .goal_y       (goal_y_r),
    .tol          (tol_r),
    .lin_gain     (lin_gain_r),
    .ang_gain     (ang_gain_r),
    .pose_x       (in_pose_x),
    .pose_y       (in_pose_y),
    .pose_heading (in_pose_heading),
    .near         (dp_near),
    .lin_speed    (dp_lin),
    .ang_rate     (dp_ang)
  );

  // Register writes; a goal write clears the latch, a close pose sets it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r   <= '0;
      goal_y_r   <= '0;
      tol_r      <= 17'd102;
      lin_gain_r <= 12'd384;
      ang_gain_r <= 12'd1536;
      reached_r  <= 1'b0;
    end else begin
      if (emit_fire && dp_near) begin
        reached_r <= 1'b1;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          gtg_pkg::REG_GOAL_X: begin
            goal_x_r  <= cfg_wdata[15:0];
            reached_r <= 1'b0;
          end
          gtg_pkg::REG_GOAL_Y: begin
            goal_y_r  <= cfg_wdata[15:0];
            reached_r <= 1'b0;
          end
          gtg_pkg::REG_TOL:      tol_r      <= cfg_wdata;
          gtg_pkg::REG_LIN_GAIN: lin_gain_r <= cfg_wdata[11:0];
          gtg_pkg::REG_ANG_GAIN: ang_gain_r <= cfg_wdata[11:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Output register: loaded on the final step, emptied when the beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_lin_r     <= hit ? '0 : dp_lin;
      out_ang_r     <= hit ? '0 : dp_ang;
      out_reached_r <= hit;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_linear_speed = out_lin_r;
  assign out_angular_rate = out_ang_r;
  assign out_goal_reached = out_reached_r;

`ifndef SYNTH
  // A reached result always carries zero commands.
  a_reached_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_reached_r) |-> (out_lin_r == '0 && out_ang_r == '0))
    else $error("reached result with nonzero command");

  // The iteration counter only runs inside the loop step.
  a_iter_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (iter_r != '0) |-> (pc_r == gtg_pkg::PC_LOOP))
    else $error("iteration counter running outside the loop");

  // A goal write clears the latch.
  a_goal_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr_en && (cfg_index == gtg_pkg::REG_GOAL_X || cfg_index == gtg_pkg::REG_GOAL_Y))
    |=> !reached_r)
    else $error("goal write did not clear the latch");

  // An accepted beat starts the program.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (pc_r == 4'd1))
    else $error("sequencer did not start after an input beat");
`endif

endmodule

`default_nettype wire

// File: sim/go_to_goal_p_controller_tb.sv
// ============================================================================
// go_to_goal_p_controller_tb
// Self-checking bench for the go-to-goal proportional controller. A short
// directed run covers the field extremes, the reached latch, zero offset and
// out-of-range register writes. Random approach trajectories toward randomly
// placed goals follow, under several register settings and idle patterns. A
// scoreboard predicts every command beat and compares it with the block.
// ============================================================================
`timescale 1ns / 1ps

// One command beat as seen on the result channel.
typedef struct packed {
  logic [gtg_pkg::LIN_W-1:0]        linear_speed;
  logic signed [gtg_pkg::ANG_W-1:0] angular_rate;
  logic                             goal_reached;
} command_t;

// Tracks the register file and the reached latch, predicts each command.
class go_to_goal_scoreboard;
  logic signed [gtg_pkg::POS_W-1:0] goal_x;
  logic signed [gtg_pkg::POS_W-1:0] goal_y;
  logic [gtg_pkg::TOL_W-1:0]        tolerance;
  logic [gtg_pkg::GAIN_W-1:0]       lin_gain;
  logic [gtg_pkg::GAIN_W-1:0]       ang_gain;
  bit                               reached;
  longint                           atan_lut[24];
  command_t                         expected_cmds[$];
  int                               errors;
  int                               cmds_seen;

  function new();
    atan_lut = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256, 128, 64, 32,
                 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};
    goal_x    = '0;
    goal_y    = '0;
    tolerance = 102;
    lin_gain  = 384;
    ang_gain  = 1536;
    reached   = 1'b0;
    errors    = 0;
    cmds_seen = 0;
  endfunction

  // Register write; a goal write clears the latch, other writes leave it alone.
  function void write_reg(logic [gtg_pkg::CFG_IDX_W-1:0] idx,
                          logic [gtg_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      gtg_pkg::REG_GOAL_X: begin
        goal_x  = data[gtg_pkg::POS_W-1:0];
        reached = 1'b0;
      end
      gtg_pkg::REG_GOAL_Y: begin
        goal_y  = data[gtg_pkg::POS_W-1:0];
        reached = 1'b0;
      end
      gtg_pkg::REG_TOL:      tolerance = data[gtg_pkg::TOL_W-1:0];
      gtg_pkg::REG_LIN_GAIN: lin_gain  = data[gtg_pkg::GAIN_W-1:0];
      gtg_pkg::REG_ANG_GAIN: ang_gain  = data[gtg_pkg::GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  // Integer square root, digit by digit, then rounded to nearest.
  function longint unsigned root_nearest(longint unsigned radicand);
    longint unsigned root, probe, rem;
    root  = 0;
    rem   = radicand;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    if (radicand - root * root > root) root = root + 1;
    return root;
  endfunction

  // Vectoring CORDIC on the offset; returns the bearing in Q3.12.
  function longint cordic_bearing(longint dx, longint dy);
    longint vx, vy, acc, tmp, sx, sy;
    int     steps;
    vx    = dx * 256;
    vy    = dy * 256;
    acc   = 0;
    steps = (gtg_pkg::CORDIC_ITERATIONS > 24) ? 24 : gtg_pkg::CORDIC_ITERATIONS;
    // Pre-rotate vectors in the left half plane by a quarter turn.
    if (vx < 0) begin
      tmp = vx;
      if (vy >= 0) begin
        vx  = vy;
        vy  = -tmp;
        acc = longint'(gtg_pkg::ANG_HALF_PI);
      end else begin
        vx  = -vy;
        vy  = tmp;
        acc = -longint'(gtg_pkg::ANG_HALF_PI);
      end
    end
    for (int i = 0; i < steps; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vy >= 0) begin
        vx  = vx + sy;
        vy  = vy - sx;
        acc = acc + atan_lut[i];
      end else begin
        vx  = vx - sy;
        vy  = vy + sx;
        acc = acc - atan_lut[i];
      end
    end
    acc = (acc + 8) >>> 4;
    if (acc > longint'(gtg_pkg::BEARING_LIMIT)) acc = longint'(gtg_pkg::BEARING_LIMIT);
    if (acc < -longint'(gtg_pkg::BEARING_LIMIT)) acc = -longint'(gtg_pkg::BEARING_LIMIT);
    return acc;
  endfunction

  // An accepted pose beat: work out the command it must produce.
  function void note_pose(logic signed [gtg_pkg::POS_W-1:0] px,
                          logic signed [gtg_pkg::POS_W-1:0] py,
                          logic signed [gtg_pkg::HEAD_W-1:0] hd);
    longint          dx, dy, err, rate;
    longint unsigned distance, speed;
    command_t        cmd;
    cmd.linear_speed = '0;
    cmd.angular_rate = '0;
    cmd.goal_reached = 1'b1;
    if (!reached) begin
      dx       = longint'(goal_x) - longint'(px);
      dy       = longint'(goal_y) - longint'(py);
      distance = root_nearest(dx * dx + dy * dy);
      if (distance > 64'h1FFFF) distance = 64'h1FFFF;
      if (distance < longint'(tolerance)) begin
        reached = 1'b1;
      end else begin
        speed = (longint'(lin_gain) * distance + 128) >> 8;
        if (speed > longint'(gtg_pkg::LIN_MAX)) speed = longint'(gtg_pkg::LIN_MAX);
        err  = cordic_bearing(dx, dy) - longint'(hd);
        rate = (longint'(ang_gain) * err + 128) >>> 8;
        if (rate > longint'(gtg_pkg::ANG_MAX)) rate = longint'(gtg_pkg::ANG_MAX);
        if (rate < longint'(gtg_pkg::ANG_MIN)) rate = longint'(gtg_pkg::ANG_MIN);
        cmd.linear_speed = speed[gtg_pkg::LIN_W-1:0];
        cmd.angular_rate = rate[gtg_pkg::ANG_W-1:0];
        cmd.goal_reached = 1'b0;
      end
    end
    expected_cmds.push_back(cmd);
  endfunction

  // An accepted command beat: compare it with the oldest prediction.
  function void check_command(command_t got);
    command_t want;
    cmds_seen++;
    if (expected_cmds.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: command %0d arrived with no pose outstanding", cmds_seen);
      return;
    end
    want = expected_cmds.pop_front();
    if (got.linear_speed !== want.linear_speed || got.angular_rate !== want.angular_rate ||
        got.goal_reached !== want.goal_reached) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: command %0d: expected speed %0d rate %0d reached %0d, got %0d %0d %0d",
                 cmds_seen, want.linear_speed, want.angular_rate, want.goal_reached,
                 got.linear_speed, got.angular_rate, got.goal_reached);
    end
  endfunction

  function int pending();
    return expected_cmds.size();
  endfunction
endclass

module go_to_goal_p_controller_tb;

  logic                                  clk = 1'b0;
  logic                                  rst_n;
  logic                                  in_valid;
  logic                                  in_stall;
  logic signed [gtg_pkg::POS_W-1:0]      in_pose_x;
  logic signed [gtg_pkg::POS_W-1:0]      in_pose_y;
  logic signed [gtg_pkg::HEAD_W-1:0]     in_pose_heading;
  logic                                  out_valid;
  logic                                  out_stall;
  logic [gtg_pkg::LIN_W-1:0]             out_linear_speed;
  logic signed [gtg_pkg::ANG_W-1:0]      out_angular_rate;
  logic                                  out_goal_reached;
  logic                                  cfg_wr_en;
  logic [gtg_pkg::CFG_IDX_W-1:0]         cfg_index;
  logic [gtg_pkg::CFG_DATA_W-1:0]        cfg_wdata;

  go_to_goal_scoreboard sb = new();

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_left     = 0;
  bit hold_request  = 1'b0;
  int sent          = 0;

  go_to_goal_p_controller i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pose_x        (in_pose_x),
    .in_pose_y        (in_pose_y),
    .in_pose_heading  (in_pose_heading),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_linear_speed (out_linear_speed),
    .out_angular_rate (out_angular_rate),
    .out_goal_reached (out_goal_reached),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Receiver: random stall, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Every command beat taken off the output is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_command('{out_linear_speed, out_angular_rate, out_goal_reached});
  end

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic logic signed [gtg_pkg::POS_W-1:0] to_pos(int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[gtg_pkg::POS_W-1:0];
  endfunction

  // Mostly headings within plus or minus pi, some over the full field range.
  function automatic int rand_heading();
    if ($urandom_range(99) < 15) return rand_between(-16384, 16383);
    return rand_between(-12868, 12868);
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(9))
      0:       return -32768;
      1:       return 32767;
      default: return rand_between(-32768, 32767);
    endcase
  endfunction

  // Offer one pose beat and hold it until the block takes it.
  task automatic send_pose(int px, int py, int hd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_pose_x       <= to_pos(px);
    in_pose_y       <= to_pos(py);
    in_pose_heading <= hd[gtg_pkg::HEAD_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pose(in_pose_x, in_pose_y, in_pose_heading);
    sent++;
    @(negedge clk);
  endtask

  // Drive one register write; the caller drops the write enable afterwards.
  task automatic write_reg(logic [gtg_pkg::CFG_IDX_W-1:0] idx,
                           logic [gtg_pkg::CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // New goal, then a pose trajectory closing in on it with some stray poses.
  task automatic run_episode(int n_steps);
    int approach, jit, ox, oy, spread, scale;
    approach = n_steps - 3;
    wait_drain();
    case ($urandom_range(3))
      0:       write_reg(gtg_pkg::REG_GOAL_X, {1'($urandom_range(1)), 16'(rand_coord())});
      1:       write_reg(gtg_pkg::REG_GOAL_Y, {1'($urandom_range(1)), 16'(rand_coord())});
      default: begin
        write_reg(gtg_pkg::REG_GOAL_X, {1'($urandom_range(1)), 16'(rand_coord())});
        write_reg(gtg_pkg::REG_GOAL_Y, {1'($urandom_range(1)), 16'(rand_coord())});
      end
    endcase
    cfg_wr_en <= 1'b0;
    case ($urandom_range(2))
      0:       spread = 65535;
      1:       spread = 4096;
      default: spread = 512;
    endcase
    ox  = rand_between(-spread, spread);
    oy  = rand_between(-spread, spread);
    jit = (sb.tolerance > 8) ? int'(sb.tolerance) : 8;
    if (jit > 4096) jit = 4096;
    for (int k = 0; k < n_steps; k++) begin
      if ($urandom_range(9) == 0) begin
        send_pose(rand_between(-32768, 32767), rand_between(-32768, 32767), rand_heading());
      end else begin
        scale = (approach > k) ? approach - k : 0;
        send_pose(int'(sb.goal_x) - ox * scale / approach + rand_between(-jit, jit),
                  int'(sb.goal_y) - oy * scale / approach + rand_between(-jit, jit),
                  rand_heading());
      end
    end
    in_valid <= 1'b0;
  endtask

  // One register setting and idle pattern, run for a number of pose beats.
  task automatic run_phase(int send_pct, int recv_pct, int lg, int ag, int tol, int n_items);
    int target;
    wait_drain();
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    write_reg(gtg_pkg::REG_TOL, gtg_pkg::CFG_DATA_W'(tol));
    write_reg(gtg_pkg::REG_LIN_GAIN, {5'($urandom_range(31)), 12'(lg)});
    write_reg(gtg_pkg::REG_ANG_GAIN, {5'($urandom_range(31)), 12'(ag)});
    cfg_wr_en <= 1'b0;
    target = sent + n_items;
    while (sent < target) run_episode(rand_between(4, 20));
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_pose_x       = '0;
    in_pose_y       = '0;
    in_pose_heading = '0;
    out_stall       = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings, goal at the origin: extremes of every field, three quadrants and two axes.
    send_pose(-32768, -32768, -16384);
    send_pose(32767, 32767, 16383);
    send_pose(32767, -32768, 12868);
    send_pose(-32768, 0, -12868);
    send_pose(0, 32767, 0);
    // Inside the tolerance: the latch sets and holds for the next pose.
    send_pose(50, 0, 0);
    send_pose(-32768, 32767, 5);
    in_valid <= 1'b0;
    wait_drain();

    // Gain and tolerance writes and unused indexes leave the latch set.
    write_reg(gtg_pkg::REG_TOL, 0);
    write_reg(gtg_pkg::REG_LIN_GAIN, 4095);
    write_reg(gtg_pkg::REG_ANG_GAIN, 4095);
    for (int idx = int'(gtg_pkg::REG_ANG_GAIN) + 1; idx < (1 << gtg_pkg::CFG_IDX_W); idx++)
      write_reg(gtg_pkg::CFG_IDX_W'(idx), '1);
    cfg_wr_en <= 1'b0;
    send_pose(-32768, -32768, 0);
    in_valid <= 1'b0;
    wait_drain();

    // Goal write clears the latch; zero offset with zero tolerance, saturation.
    write_reg(gtg_pkg::REG_GOAL_X, 0);
    cfg_wr_en <= 1'b0;
    send_pose(0, 0, 16383);
    send_pose(0, 0, -16384);
    send_pose(-32768, -32768, -16384);
    send_pose(32767, 1, 16383);
    send_pose(32767, 0, -16384);
    in_valid <= 1'b0;
    wait_drain();

    // Goal at the corner, zero gains, then the largest tolerance.
    write_reg(gtg_pkg::REG_GOAL_X, 32767);
    write_reg(gtg_pkg::REG_GOAL_Y, 17'h18000);
    write_reg(gtg_pkg::REG_TOL, 102);
    write_reg(gtg_pkg::REG_LIN_GAIN, 0);
    write_reg(gtg_pkg::REG_ANG_GAIN, 0);
    cfg_wr_en <= 1'b0;
    send_pose(-32768, 32767, 100);
    send_pose(32767, -32768, 0);
    in_valid <= 1'b0;
    wait_drain();
    write_reg(gtg_pkg::REG_TOL, 131071);
    write_reg(gtg_pkg::REG_GOAL_Y, 17'h08000);
    cfg_wr_en <= 1'b0;
    send_pose(-32768, 32767, 0);
    send_pose(0, 0, 0);
    in_valid <= 1'b0;

    // Random trajectories under several settings and idle patterns.
    run_phase(0, 0, 384, 1536, 102, 300);
    run_phase(87, 0, rand_between(0, 4095), rand_between(0, 4095), rand_between(0, 600), 300);
    run_phase(0, 87, 4095, 4095, rand_between(0, 3000), 300);
    run_phase(24, 24, rand_between(0, 1024), rand_between(0, 4095), rand_between(1, 400), 300);

    // Long receiver hold-off while poses keep coming, so the input backs up.
    wait_drain();
    send_idle_pct = 0;
    stall_pct     = 0;
    @(posedge clk);
    hold_request = 1'b1;
    @(negedge clk);
    run_episode(30);
    run_episode(20);

    in_valid <= 1'b0;
    wait_drain();
    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("go_to_goal_p_controller: match");
    end else begin
      $display("go_to_goal_p_controller: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("go_to_goal_p_controller: mismatch");
    $finish;
  end
endmodule

// File: sim.f
sv/gtg_pkg.sv
sv/gtg_dp.sv
sv/go_to_goal_p_controller.sv
sim/go_to_goal_p_controller_tb.sv
